/* rtl/core/ssbf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssbf_pkg
// Shared sizes, register indexes and control structs of the sprite blitter.
// ----------------------------------------------------------------------------
package ssbf_pkg;

  localparam int unsigned MAX_SPRITE_SIDE = 8;
  localparam int unsigned MAX_FRAMES_SIDE = 16;
  localparam int unsigned SHEET_DEPTH     = 16384;
  localparam int unsigned SHEET_AW        = $clog2(SHEET_DEPTH);

  // Port widths
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_ACROSS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_DOWN   = 3'd3;

  // Item kinds on tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef struct packed {
    logic load;      // write one sheet entry from the input item
    logic start;     // latch draw item, clamp frame
    logic div_step;  // one cell-row subtraction
    logic col_add;   // add cell column offset to base
    logic run;       // issue pixel reads
  } cmd_t;

  typedef struct packed {
    logic div_done;    // remainder below frames_across
    logic last_issue;  // final pixel read issued this cycle
  } sts_t;

endpackage : ssbf_pkg
`default_nettype wire

/* rtl/core/ssbf_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssbf_ctrl
// Sequencer: takes items, walks frame locate and pixel issue phases.
// ----------------------------------------------------------------------------
module ssbf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_op_i,
  output logic               in_ready_o,
  input  wire ssbf_pkg::sts_t sts_i,
  output ssbf_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   accept;

  assign accept     = in_valid_i && ready_q;
  assign in_ready_o = ready_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept && (in_op_i == ssbf_pkg::OP_LOAD);
    cmd_o.start    = accept && (in_op_i == ssbf_pkg::OP_DRAW);
    cmd_o.div_step = (state_q == ST_DIV) && !sts_i.div_done;
    cmd_o.col_add  = (state_q == ST_DIV) && sts_i.div_done;
    cmd_o.run      = (state_q == ST_RUN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.start) begin
            state_q <= ST_DIV;
            ready_q <= 1'b0;
          end
        end
        ST_DIV: begin
          if (sts_i.div_done) state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (sts_i.last_issue) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule : ssbf_ctrl
`default_nettype wire

/* rtl/core/ssbf_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssbf_dp
// Datapath: config registers, sheet memory, address generation, output stage.
// ----------------------------------------------------------------------------
module ssbf_dp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [ssbf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [ssbf_pkg::CFG_DAT_W-1:0]        cfg_data_i,
  input  wire logic [ssbf_pkg::S_TDATA_W-1:0]        in_data_i,
  input  wire ssbf_pkg::cmd_t                        cmd_i,
  output ssbf_pkg::sts_t                             sts_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [ssbf_pkg::M_TDATA_W-1:0]             out_data_o,
  output logic                                       out_last_o
);

  localparam int unsigned AW = ssbf_pkg::SHEET_AW;

  // Config registers, stored already clamped
  logic [3:0] w_q, h_q;
  logic [4:0] fa_q, fd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= 4'(ssbf_pkg::MAX_SPRITE_SIDE);
      h_q  <= 4'(ssbf_pkg::MAX_SPRITE_SIDE);
      fa_q <= 5'd1;
      fd_q <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssbf_pkg::CFG_SPRITE_WIDTH:
          w_q <= (cfg_data_i[3:0] == 4'd0) ? 4'd1 :
                 (cfg_data_i[3:0] > 4'(ssbf_pkg::MAX_SPRITE_SIDE)) ?
                 4'(ssbf_pkg::MAX_SPRITE_SIDE) : cfg_data_i[3:0];
        ssbf_pkg::CFG_SPRITE_HEIGHT:
          h_q <= (cfg_data_i[3:0] == 4'd0) ? 4'd1 :
                 (cfg_data_i[3:0] > 4'(ssbf_pkg::MAX_SPRITE_SIDE)) ?
                 4'(ssbf_pkg::MAX_SPRITE_SIDE) : cfg_data_i[3:0];
        ssbf_pkg::CFG_FRAMES_ACROSS:
          fa_q <= (cfg_data_i == 5'd0) ? 5'd1 :
                  (cfg_data_i > 5'(ssbf_pkg::MAX_FRAMES_SIDE)) ?
                  5'(ssbf_pkg::MAX_FRAMES_SIDE) : cfg_data_i;
        ssbf_pkg::CFG_FRAMES_DOWN:
          fd_q <= (cfg_data_i == 5'd0) ? 5'd1 :
                  (cfg_data_i > 5'(ssbf_pkg::MAX_FRAMES_SIDE)) ?
                  5'(ssbf_pkg::MAX_FRAMES_SIDE) : cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input item fields
  logic [13:0]        ld_addr;
  logic [8:0]         ld_val;
  logic [7:0]         frame_in;
  logic               mx_in, my_in;
  logic signed [11:0] ox_in, oy_in;

  assign ld_addr  = in_data_i[13:0];
  assign ld_val   = in_data_i[22:14];
  assign frame_in = in_data_i[30:23];
  assign mx_in    = in_data_i[31];
  assign my_in    = in_data_i[32];
  assign ox_in    = in_data_i[44:33];
  assign oy_in    = in_data_i[56:45];

  // Frame clamp and cell locate
  logic [9:0]  n_frames;
  logic [9:0]  last_frame;
  logic [7:0]  frame_clamped;
  logic [7:0]  stride_d;
  logic [10:0] row_step;
  logic [8:0]  col_off;
  logic        rem_ge;

  logic [7:0]         rem_q, stride_q;
  logic [AW-1:0]      base_q;
  logic               mx_q, my_q;
  logic signed [11:0] ox_q, oy_q;

  assign n_frames      = 10'(fa_q) * 10'(fd_q);
  assign last_frame    = n_frames - 10'd1;
  assign frame_clamped = ({2'b00, frame_in} > last_frame) ? last_frame[7:0] : frame_in;
  assign stride_d      = 8'(9'(w_q) * 9'(fa_q));
  assign row_step      = 11'(h_q) * 11'(stride_q);
  assign col_off       = 9'(w_q) * 9'(rem_q[4:0]);
  assign rem_ge        = rem_q >= {3'b000, fa_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q    <= frame_clamped;
      stride_q <= stride_d;
      base_q   <= '0;
      mx_q     <= mx_in;
      my_q     <= my_in;
      ox_q     <= ox_in;
      oy_q     <= oy_in;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_q - {3'b000, fa_q};
      base_q <= base_q + AW'(row_step);
    end else if (cmd_i.col_add) begin
      base_q <= base_q + AW'(col_off);
    end
  end

  // Pixel walk
  logic [2:0]    x_q, y_q;
  logic [3:0]    wm1, hm1, sx4, sy4;
  logic [10:0]   row_off;
  logic [AW-1:0] raddr;
  logic          x_last, y_last;
  logic          s1_v_q, out_v_q;
  logic          out_free, can_issue, issue;

  assign wm1     = w_q - 4'd1;
  assign hm1     = h_q - 4'd1;
  assign sx4     = mx_q ? (wm1 - {1'b0, x_q}) : {1'b0, x_q};
  assign sy4     = my_q ? (hm1 - {1'b0, y_q}) : {1'b0, y_q};
  assign row_off = 11'(sy4[2:0]) * 11'(stride_q);
  assign raddr   = base_q + AW'(row_off) + AW'(sx4[2:0]);
  assign x_last  = ({1'b0, x_q} == wm1);
  assign y_last  = ({1'b0, y_q} == hm1);

  assign out_free  = !out_v_q || out_ready_i;
  assign can_issue = !s1_v_q || out_free;
  assign issue     = cmd_i.run && can_issue;

  assign sts_o.div_done   = !rem_ge;
  assign sts_o.last_issue = issue && x_last && y_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (cmd_i.start) begin
      x_q <= '0;
      y_q <= '0;
    end else if (issue) begin
      if (x_last) begin
        x_q <= '0;
        y_q <= y_q + 3'd1;
      end else begin
        x_q <= x_q + 3'd1;
      end
    end
  end

  // Sheet memory, one write and one registered read port
  logic [8:0] sheet_mem [ssbf_pkg::SHEET_DEPTH];
  logic [8:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && ({1'b0, ld_addr} < 15'(ssbf_pkg::SHEET_DEPTH))) begin
      sheet_mem[ld_addr[AW-1:0]] <= ld_val;
    end
    if (issue) begin
      rdata_q <= sheet_mem[raddr];
    end
  end

  // Read stage side info and output register. Screen coordinates are formed
  // at issue, so a following draw may reload the origin while this stage waits.
  logic signed [12:0] s1_px_q, s1_py_q;
  logic               s1_last_q;
  logic signed [12:0] px_q, py_q;
  logic [7:0]         color_q;
  logic               we_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (issue)         s1_v_q <= 1'b1;
      else if (out_free) s1_v_q <= 1'b0;
      if (out_free)      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_px_q   <= {ox_q[11], ox_q} + {10'd0, x_q};
      s1_py_q   <= {oy_q[11], oy_q} + {10'd0, y_q};
      s1_last_q <= x_last && y_last;
    end
    if (out_free && s1_v_q) begin
      px_q    <= s1_px_q;
      py_q    <= s1_py_q;
      color_q <= rdata_q[8] ? 8'd0 : rdata_q[7:0];
      we_q    <= ~rdata_q[8];
      last_q  <= s1_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = {5'd0, we_q, color_q, py_q, px_q};
  assign out_last_o  = last_q;

endmodule : ssbf_dp
`default_nettype wire

/* rtl/core/sprite_sheet_blitter_with_flip_top.sv */
`default_nettype none
// Load item: written to the sheet as it is taken, no result. Draw item: a
// subtract loop finds the frame cell row and adds the column offset, then one
// sheet read per cycle while the output is not stalled, W*H reads; each pixel
// passes the memory read register and the output register. Input is held off
// from draw accept until the last read is issued. Reset restores the size
// registers to 8, 8, 1, 1 and empties the pipeline; the sheet is not cleared.
// ----------------------------------------------------------------------------
// sprite_sheet_blitter_with_flip_top
// Sprite sheet blitter with per-axis mirroring and transparent pixels.
// ----------------------------------------------------------------------------
module sprite_sheet_blitter_with_flip_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Config write port
  input  wire logic                               cfg_we_i,
  input  wire logic [ssbf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [ssbf_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  // Input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata, low bit up: load_address[13:0], load_value[22:14],
  // frame_number[30:23], mirror_x[31], mirror_y[32], origin_x[44:33],
  // origin_y[56:45], zero fill[63:57]
  input  wire logic [ssbf_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // tuser: op[0] (0 load, 1 draw)
  input  wire logic                               s_axis_tuser,
  // Output stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata, low bit up: pixel_x[12:0], pixel_y[25:13], color[33:26],
  // write_enable[34], zero fill[39:35]
  output logic [ssbf_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  output logic                                    m_axis_tlast
);

  ssbf_pkg::cmd_t cmd;
  ssbf_pkg::sts_t sts;

  // Sequencer: IDLE takes items, DIV finds the cell row and adds the column offset, RUN issues reads
  ssbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: the read pipeline runs on its own handshake, so results of a
  // draw can still drain while the next item is taken
  ssbf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule : sprite_sheet_blitter_with_flip_top
`default_nettype wire

/* rtl/core/ssbf_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssbf_chk
// Port-level checks of the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
module ssbf_chk (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [ssbf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                           m_axis_tlast
);

  // Held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Held result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A draw holds off the input side while the frame is walked
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input taken during draw");

  // A load never blocks the next item
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("load stalled input");

endmodule : ssbf_chk

bind sprite_sheet_blitter_with_flip_top ssbf_chk u_ssbf_chk (.*);
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sprite sheet blitter: a short directed run,
// then several register settings with mostly well-formed load/draw sequences
// and random source and sink pacing.
// Each draw's pixels are predicted and compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ssbf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES  = 16;    // idle margin before config writes / end
  localparam int REPORT_LIMIT   = 10;

  // One output pixel, as the blitter presents it
  typedef struct packed {
    logic signed [12:0] px;
    logic signed [12:0] py;
    logic [7:0]         color;
    logic               we;
    logic               last;
  } pixel_t;

  // --------------------------------------------------------------------------
  // Blit scoreboard: keeps its own sheet and size registers, expands each
  // accepted draw into its pixels and checks the output stream against them.
  // --------------------------------------------------------------------------
  class blit_scoreboard;
    logic [8:0] sheet [SHEET_DEPTH];
    logic [3:0] reg_w;
    logic [3:0] reg_h;
    logic [4:0] reg_fa;
    logic [4:0] reg_fd;
    pixel_t     pixels_due[$];
    int         failures;

    function new();
      reg_w    = 4'd8;
      reg_h    = 4'd8;
      reg_fa   = 5'd1;
      reg_fd   = 5'd1;
      failures = 0;
      foreach (sheet[i]) sheet[i] = '0;
    endfunction

    // zero acts as one, oversize saturates
    function int clamp_side(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function int cell_w();
      return clamp_side(reg_w, MAX_SPRITE_SIDE);
    endfunction

    function int cell_h();
      return clamp_side(reg_h, MAX_SPRITE_SIDE);
    endfunction

    function int frame_count();
      return clamp_side(reg_fa, MAX_FRAMES_SIDE) * clamp_side(reg_fd, MAX_FRAMES_SIDE);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_SPRITE_WIDTH:  reg_w  = val[3:0];
        CFG_SPRITE_HEIGHT: reg_h  = val[3:0];
        CFG_FRAMES_ACROSS: reg_fa = val[4:0];
        CFG_FRAMES_DOWN:   reg_fd = val[4:0];
        default: ;
      endcase
    endfunction

    // Sheet entry of cell pixel (sx, sy) of a frame, frame clamped to the last one
    function int cell_entry(int frame, int sx, int sy);
      int w, h, fa, stride;
      w  = cell_w();
      h  = cell_h();
      fa = clamp_side(reg_fa, MAX_FRAMES_SIDE);
      if (frame > frame_count() - 1) frame = frame_count() - 1;
      stride = w * fa;
      return (h * (frame / fa) * stride + w * (frame % fa) + sy * stride + sx)
             % SHEET_DEPTH;
    endfunction

    function void note_item(logic op, logic [S_TDATA_W-1:0] data);
      int     w, h, ox, oy, sx, sy;
      logic [8:0] v;
      pixel_t p;
      if (op == OP_LOAD) begin
        sheet[data[13:0]] = data[22:14];
        return;
      end
      w  = cell_w();
      h  = cell_h();
      ox = $signed(data[44:33]);
      oy = $signed(data[56:45]);
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          sx      = data[31] ? (w - 1 - x) : x;
          sy      = data[32] ? (h - 1 - y) : y;
          v       = sheet[cell_entry(data[30:23], sx, sy)];
          p.px    = 13'(ox + x);
          p.py    = 13'(oy + y);
          p.we    = ~v[8];
          p.color = v[8] ? 8'd0 : v[7:0];
          p.last  = (y == h - 1) && (x == w - 1);
          pixels_due.push_back(p);
        end
      end
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void check_pixel(logic [M_TDATA_W-1:0] data, logic last_flag);
      pixel_t got, want;
      got.px    = data[12:0];
      got.py    = data[25:13];
      got.color = data[33:26];
      got.we    = data[34];
      got.last  = last_flag;
      if (pixels_due.size() == 0) begin
        note_failure($sformatf("unexpected pixel x=%0d y=%0d color=%0d we=%0b last=%0b",
                               got.px, got.py, got.color, got.we, got.last));
        return;
      end
      want = pixels_due.pop_front();
      if (got !== want)
        note_failure($sformatf({"pixel mismatch: exp x=%0d y=%0d color=%0d we=%0b last=%0b",
                                " / got x=%0d y=%0d color=%0d we=%0b last=%0b"},
                               want.px, want.py, want.color, want.we, want.last,
                               got.px, got.py, got.color, got.we, got.last));
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    // anything still expected at the end is a failure too
    function int close_out();
      if (pixels_due.size() != 0)
        note_failure($sformatf("%0d expected pixels never arrived", pixels_due.size()));
      return failures;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // tdata, low bit up: load_address, load_value, frame_number, mirror_x,
  // mirror_y, origin_x, origin_y, zero fill
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  // tuser: op
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // tdata, low bit up: pixel_x, pixel_y, color, write_enable, zero fill
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sprite_sheet_blitter_with_flip_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  blit_scoreboard sb = new();

  // Sheet entries the stimulus has already loaded; draws only touch these,
  // so no unwritten entry is ever read.
  bit sheet_loaded [SHEET_DEPTH];
  int items_sent     = 0;
  int src_burst_left = 0;
  int stall_cycles   = 0;

  // --------------------------------------------------------------------------
  // Output side: every handshake is checked against the oldest pixel due
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_pixel(m_axis_tdata, m_axis_tlast);
  end

  // Sink pacing: short runs with short stalls, now and then a long stall,
  // and now and then a long stretch of steady ready
  initial begin : sink_pacing
    int run_len, stall;
    @(posedge clk_i);
    forever begin
      run_len = ($urandom_range(0, 99) < 10) ? $urandom_range(100, 300)
                                             : $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                           : $urandom_range(15, 40);
      m_axis_tready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
  end

  // Watchdog: a run of cycles with neither an input nor an output handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL sprite_sheet_blitter_with_flip_top");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All tasks start and return just after a rising edge.
  // --------------------------------------------------------------------------

  // Source gaps: mostly none or short, a few long, and bursts with none at all
  function automatic int idle_len();
    int r;
    if (src_burst_left > 0) begin
      src_burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      src_burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [8:0] pick_color();
    case ($urandom_range(0, 19))
      0:       return 9'h100;  // most negative, transparent
      1:       return 9'h0FF;  // brightest opaque
      2:       return 9'h000;
      3:       return 9'h1FF;  // -1, transparent
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [11:0] pick_origin();
    case ($urandom_range(0, 9))
      0:       return 12'h800;  // -2048
      1:       return 12'h7FF;  // 2047
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Frame numbers: mostly inside the sheet, some at and beyond its end
  function automatic int pick_frame();
    int n, r;
    n = sb.frame_count();
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, n - 1);
    if (r < 78) return n - 1;
    if (r < 86) return 255;
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_item(logic [13:0] addr, logic [8:0] val,
                                                      logic [7:0] frame, logic mx, logic my,
                                                      logic [11:0] ox, logic [11:0] oy);
    return {7'd0, oy, ox, my, mx, frame, val, addr};
  endfunction

  // valid stays high across back-to-back items; it only drops for a gap or a drain
  task automatic send_item(input logic op, input logic [S_TDATA_W-1:0] data);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(op, data);
    items_sent++;
  endtask

  // unused draw fields carry random junk on a load, and the other way round
  task automatic send_load(input int addr, input logic [8:0] val);
    send_item(OP_LOAD, pack_item(14'(addr), val, 8'($urandom), 1'($urandom),
                                 1'($urandom), 12'($urandom), 12'($urandom)));
    sheet_loaded[addr] = 1'b1;
  endtask

  task automatic send_draw(input int frame, input logic mx, input logic my,
                           input logic [11:0] ox, input logic [11:0] oy);
    send_item(OP_DRAW, pack_item(14'($urandom), 9'($urandom), 8'(frame), mx, my, ox, oy));
  endtask

  // Load whatever the chosen cell still lacks (plus a few rewrites), then draw.
  // A broken sequence stops partway through the loads and never draws.
  task automatic draw_sequence(input bit complete);
    int frame, w, cut, idx;
    frame = pick_frame();
    w     = sb.cell_w();
    cut   = complete ? w * sb.cell_h() : $urandom_range(0, w * sb.cell_h() - 1);
    for (int k = 0; k < cut; k++) begin
      idx = sb.cell_entry(frame, k % w, k / w);
      if (!sheet_loaded[idx] || $urandom_range(0, 9) == 0)
        send_load(idx, pick_color());
    end
    if (complete)
      send_draw(frame, 1'($urandom), 1'($urandom), pick_origin(), pick_origin());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Source goes quiet until every pixel due has come out, then a margin so
  // a trailing load is surely done before any register changes
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register setting, then random traffic until the item budget is spent.
  // poke_unused also writes the indexes above the last register.
  task automatic run_phase(input int w, input int h, input int fa, input int fd,
                           input int budget, input bit poke_unused);
    int target, r;
    drain();
    write_reg(CFG_SPRITE_WIDTH,  CFG_DAT_W'(w));
    write_reg(CFG_SPRITE_HEIGHT, CFG_DAT_W'(h));
    write_reg(CFG_FRAMES_ACROSS, CFG_DAT_W'(fa));
    write_reg(CFG_FRAMES_DOWN,   CFG_DAT_W'(fd));
    if (poke_unused) begin
      for (int i = CFG_FRAMES_DOWN + 1; i < 2 ** CFG_IDX_W; i++)
        write_reg(CFG_IDX_W'(i), CFG_DAT_W'($urandom));
    end
    cfg_we_i <= 1'b0;
    target = items_sent + budget;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 12)
        send_load($urandom_range(0, SHEET_DEPTH - 1), pick_color());
      else if (r < 17)
        draw_sequence(1'b0);
      else
        draw_sequence(1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 2x2 cells, frame grid left at its reset size (one cell), so
    // any frame number clamps to frame 0.
    write_reg(CFG_SPRITE_WIDTH,  5'd2);
    write_reg(CFG_SPRITE_HEIGHT, 5'd2);
    cfg_we_i <= 1'b0;
    send_load(0, 9'h100);        // most negative: transparent
    send_load(1, 9'h0FF);        // max opaque color
    send_load(2, 9'h000);        // zero is opaque
    send_load(3, 9'h1FF);        // -1: transparent
    send_load(SHEET_DEPTH - 1, 9'h055);  // top address
    send_draw(0,   1'b0, 1'b0, 12'h800, 12'h800);  // no mirror, most negative origin
    send_draw(0,   1'b1, 1'b0, 12'h7FF, 12'h7FF);  // x mirror, largest origin
    send_draw(0,   1'b0, 1'b1, 12'h000, 12'h000);  // y mirror
    send_draw(0,   1'b1, 1'b1, 12'hFFF, 12'h001);  // both mirrors
    send_draw(255, 1'b0, 1'b0, pick_origin(), pick_origin());  // frame past the end

    // Random phases over several register settings
    run_phase(1,  1, 16, 16, 50, 1'b0);  // smallest cells, largest grid
    run_phase(0,  0,  0,  0, 25, 1'b0);  // zero sizes act as one
    run_phase(8,  8,  1,  1, 80, 1'b0);  // reset setting, largest single cell
    run_phase(15, 3, 31,  2, 45, 1'b0);  // oversized width and frames_across
    run_phase(3,  5,  5,  3, 45, 1'b1);  // odd sizes, writes to unused indexes
    run_phase(8,  8, 16, 16, 60, 1'b0);  // full sheet
    run_phase($urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(0, 31), $urandom_range(0, 31), 35, 1'b0);

    drain();
    if (sb.close_out() == 0) begin
      $display("PASS sprite_sheet_blitter_with_flip_top");
    end else begin
      $display("FAIL sprite_sheet_blitter_with_flip_top");
    end
    $finish;
  end

endmodule

/* sprite_sheet_blitter_with_flip_top.f */
rtl/core/ssbf_pkg.sv
rtl/core/ssbf_ctrl.sv
rtl/core/ssbf_dp.sv
rtl/core/sprite_sheet_blitter_with_flip_top.sv
rtl/core/ssbf_chk.sv
bench/tb_top.sv
